// ----- rtl/rssd_pkg.sv -----
`timescale 1ns / 1ps

package rssd_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_ORIGIN_X    = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y    = 3'd1;
    localparam logic [2:0] CFG_LAST_ROW_Y  = 3'd2;
    localparam logic [2:0] CFG_CLIP_LEFT   = 3'd3;
    localparam logic [2:0] CFG_CLIP_TOP    = 3'd4;
    localparam logic [2:0] CFG_CLIP_RIGHT  = 3'd5;
    localparam logic [2:0] CFG_CLIP_BOTTOM = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int PEN_X_W = 18;
    localparam int PEN_Y_W = 17;
    localparam logic signed [PEN_X_W:0] PEN_X_MAX = 19'sd131071;

    // op queue between decoder and clipper
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_CMD    = 3'd1,
        PH_RUNVAL = 3'd2,
        PH_LIT    = 3'd3,
        PH_SKIP   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_SPAN  = 2'd1,
        KIND_DONE  = 2'd2
    } t_kind;

    typedef struct packed {
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic signed [15:0] last_row_y;
        logic signed [15:0] clip_left;
        logic signed [15:0] clip_top;
        logic signed [15:0] clip_right;
        logic signed [15:0] clip_bottom;
    } t_cfg;

    typedef struct packed {
        t_kind                      kind;
        logic signed [PEN_X_W-1:0]  x;
        logic signed [PEN_Y_W-1:0]  y;
        logic [6:0]                 count;
        logic [7:0]                 value;
    } t_op;

    // pen advance, saturating at the top of the 18-bit signed range
    function automatic logic signed [PEN_X_W-1:0] pen_add(
        input logic signed [PEN_X_W-1:0] x,
        input logic [7:0]                n
    );
        logic signed [PEN_X_W:0] v;
        v = {x[PEN_X_W-1], x} + $signed({{(PEN_X_W-7){1'b0}}, n});
        if (v > PEN_X_MAX) begin
            return PEN_X_MAX[PEN_X_W-1:0];
        end
        return v[PEN_X_W-1:0];
    endfunction

endpackage

// ----- rtl/rssd_front.sv -----
`timescale 1ns / 1ps

module rssd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rssd_pkg::t_cfg     i_cfg,
    input  logic               i_accept,
    input  logic [7:0]         i_data_byte,
    input  logic               i_frame_start,
    output logic               o_push,
    output rssd_pkg::t_op      o_op
);
    import rssd_pkg::*;

    t_phase                    r_phase, n_phase;
    logic [6:0]                r_rem, n_rem;
    logic signed [PEN_X_W-1:0] r_pen_x, n_pen_x;
    logic signed [PEN_Y_W-1:0] r_pen_y, n_pen_y;

    logic                      empty_clip;
    t_phase                    eff_phase;
    logic signed [PEN_X_W-1:0] base_x;
    logic signed [PEN_Y_W-1:0] base_y;
    logic signed [PEN_X_W-1:0] org_x;
    logic signed [PEN_Y_W-1:0] org_y;
    logic signed [PEN_Y_W-1:0] last_y;
    logic [6:0]                cmd_n;
    logic                      cmd_t;
    logic                      at_last_row;

    assign org_x  = {{(PEN_X_W-16){i_cfg.origin_x[15]}}, i_cfg.origin_x};
    assign org_y  = {{(PEN_Y_W-16){i_cfg.origin_y[15]}}, i_cfg.origin_y};
    assign last_y = {{(PEN_Y_W-16){i_cfg.last_row_y[15]}}, i_cfg.last_row_y};

    assign empty_clip = (i_cfg.clip_right <= i_cfg.clip_left) ||
                        (i_cfg.clip_bottom <= i_cfg.clip_top) ||
                        (i_cfg.origin_y > i_cfg.last_row_y);

    // a start word restarts decoding from the command phase at the origin
    assign eff_phase = i_frame_start ? PH_CMD : r_phase;
    assign base_x    = i_frame_start ? org_x : r_pen_x;
    assign base_y    = i_frame_start ? org_y : r_pen_y;
    assign cmd_n     = i_data_byte[7:1];
    assign cmd_t     = i_data_byte[0];
    assign at_last_row = (base_y >= last_y);

    // next state
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            if (i_frame_start && empty_clip) begin
                n_phase = PH_IDLE;
            end else begin
                unique case (eff_phase)
                    PH_CMD: begin
                        if (cmd_n != 7'd0) begin
                            n_phase = cmd_t ? PH_LIT : PH_RUNVAL;
                        end else if (cmd_t) begin
                            n_phase = PH_SKIP;
                        end else if (at_last_row) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_phase = PH_CMD;
                        end
                    end
                    PH_RUNVAL: n_phase = PH_CMD;
                    PH_LIT:    n_phase = (r_rem == 7'd1) ? PH_CMD : PH_LIT;
                    PH_SKIP:   n_phase = PH_CMD;
                    default:   n_phase = r_phase;
                endcase
            end
        end
    end

    // outputs and datapath
    always_comb begin
        n_rem   = r_rem;
        n_pen_x = r_pen_x;
        n_pen_y = r_pen_y;
        o_push  = 1'b0;
        o_op    = '{kind: KIND_DONE, x: '0, y: '0, count: '0, value: '0};
        if (i_accept) begin
            n_pen_x = base_x;
            n_pen_y = base_y;
            if (i_frame_start) begin
                n_rem = 7'd0;
            end
            if (i_frame_start && empty_clip) begin
                o_push = 1'b1;
            end else begin
                unique case (eff_phase)
                    PH_CMD: begin
                        if (cmd_n != 7'd0) begin
                            n_rem = cmd_n;
                        end else if (!cmd_t) begin
                            if (at_last_row) begin
                                o_push = 1'b1;
                                n_rem  = 7'd0;
                            end else begin
                                n_pen_y = base_y + PEN_Y_W'(1);
                                n_pen_x = org_x;
                            end
                        end
                    end
                    PH_RUNVAL: begin
                        o_push       = 1'b1;
                        o_op.kind    = KIND_SPAN;
                        o_op.x       = r_pen_x;
                        o_op.y       = r_pen_y;
                        o_op.count   = r_rem;
                        o_op.value   = i_data_byte;
                        n_pen_x      = pen_add(r_pen_x, {1'b0, r_rem});
                        n_rem        = 7'd0;
                    end
                    PH_LIT: begin
                        o_push       = 1'b1;
                        o_op.kind    = KIND_PIXEL;
                        o_op.x       = r_pen_x;
                        o_op.y       = r_pen_y;
                        o_op.count   = 7'd1;
                        o_op.value   = i_data_byte;
                        n_pen_x      = pen_add(r_pen_x, 8'd1);
                        n_rem        = r_rem - 7'd1;
                    end
                    PH_SKIP: begin
                        n_pen_x = pen_add(r_pen_x, i_data_byte);
                    end
                    default: begin
                        // idle: word ignored
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_rem   <= '0;
            r_pen_x <= '0;
            r_pen_y <= '0;
        end else begin
            r_phase <= n_phase;
            r_rem   <= n_rem;
            r_pen_x <= n_pen_x;
            r_pen_y <= n_pen_y;
        end
    end

endmodule

// ----- rtl/rssd_queue.sv -----
`timescale 1ns / 1ps

module rssd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rssd_pkg::t_op  i_op,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output rssd_pkg::t_op  o_op
);
    import rssd_pkg::*;

    t_op            r_mem [QDEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QAW:0]   r_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_op    = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (QAW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (QAW+1)'(1);
            end
        end
    end

endmodule

// ----- rtl/rssd_back.sv -----
`timescale 1ns / 1ps

module rssd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rssd_pkg::t_cfg     i_cfg,
    input  logic               i_empty,
    input  rssd_pkg::t_op      i_op,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_kind,
    output logic signed [15:0] o_pos_x,
    output logic signed [15:0] o_pos_y,
    output logic [6:0]         o_span_length,
    output logic [7:0]         o_pixel_value,
    output logic               o_frame_last
);
    import rssd_pkg::*;

    logic                      r_valid;
    t_kind                     r_kind;
    logic signed [15:0]        r_pos_x, r_pos_y;
    logic [6:0]                r_len;
    logic [7:0]                r_value;
    logic                      r_last;

    logic signed [PEN_X_W:0]   x_ext, left_ext, right_ext, lo, hi, span_end, diff;
    logic signed [PEN_Y_W-1:0] top_ext, bot_ext;
    logic                      visible, is_done, emit;

    assign x_ext     = {i_op.x[PEN_X_W-1], i_op.x};
    assign left_ext  = {{(PEN_X_W+1-16){i_cfg.clip_left[15]}}, i_cfg.clip_left};
    assign right_ext = {{(PEN_X_W+1-16){i_cfg.clip_right[15]}}, i_cfg.clip_right};
    assign top_ext   = {{(PEN_Y_W-16){i_cfg.clip_top[15]}}, i_cfg.clip_top};
    assign bot_ext   = {{(PEN_Y_W-16){i_cfg.clip_bottom[15]}}, i_cfg.clip_bottom};

    // a single pixel is a span of one, so both go through the same clip
    assign span_end = x_ext + $signed({{(PEN_X_W-6){1'b0}}, i_op.count});
    assign lo       = (x_ext > left_ext) ? x_ext : left_ext;
    assign hi       = (span_end < right_ext) ? span_end : right_ext;
    assign diff     = hi - lo;
    assign visible  = (hi > lo) && (i_op.y >= top_ext) && (i_op.y < bot_ext);
    assign is_done  = (i_op.kind == KIND_DONE);

    assign o_pop = !i_empty && (!r_valid || i_out_ready);
    assign emit  = o_pop && (is_done || visible);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (emit) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind <= i_op.kind;
            if (is_done) begin
                r_pos_x <= '0;
                r_pos_y <= '0;
                r_len   <= '0;
                r_value <= '0;
                r_last  <= 1'b1;
            end else begin
                r_pos_x <= lo[15:0];
                r_pos_y <= i_op.y[15:0];
                r_len   <= diff[6:0];
                r_value <= i_op.value;
                r_last  <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_valid;
    assign o_kind        = r_kind;
    assign o_pos_x       = r_pos_x;
    assign o_pos_y       = r_pos_y;
    assign o_span_length = r_len;
    assign o_pixel_value = r_value;
    assign o_frame_last  = r_last;

endmodule

// ----- rtl/rle_sprite_span_decoder_core.sv -----
`timescale 1ns / 1ps

// Run-length sprite span decoder. One coded byte is taken per clock when the
// op queue has room; the decoder updates phase and pen in that cycle and
// posts run, pixel and frame-done ops to a four-entry queue. The clipper
// pops one op per clock, when the output register is free or taken, into it
// unless the op clips away; a word reaches the output via the queue and the
// output register. The sustained rate is one byte per cycle; an output stall
// backs up through the queue to the input ready. Clip and origin registers
// are read live and should be written only while no byte or word is in flight.

module rle_sprite_span_decoder_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rssd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rssd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [7:0]                         i_data_byte,
    input  logic                               i_frame_start,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [1:0]                         o_kind,
    output logic signed [15:0]                 o_pos_x,
    output logic signed [15:0]                 o_pos_y,
    output logic [6:0]                         o_span_length,
    output logic [7:0]                         o_pixel_value,
    output logic                               o_frame_last
);
    import rssd_pkg::*;

    t_cfg  r_cfg;
    logic  accept, push, pop, full, empty;
    t_op   push_op, head_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_X:    r_cfg.origin_x    <= i_cfg_data;
                CFG_ORIGIN_Y:    r_cfg.origin_y    <= i_cfg_data;
                CFG_LAST_ROW_Y:  r_cfg.last_row_y  <= i_cfg_data;
                CFG_CLIP_LEFT:   r_cfg.clip_left   <= i_cfg_data;
                CFG_CLIP_TOP:    r_cfg.clip_top    <= i_cfg_data;
                CFG_CLIP_RIGHT:  r_cfg.clip_right  <= i_cfg_data;
                CFG_CLIP_BOTTOM: r_cfg.clip_bottom <= i_cfg_data;
                default: begin
                    // unused index
                end
            endcase
        end
    end

    assign o_in_ready = !full;
    assign accept     = i_in_valid && o_in_ready;

    rssd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_accept      (accept),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .o_push        (push),
        .o_op          (push_op)
    );

    rssd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_op    (head_op)
    );

    rssd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_empty       (empty),
        .i_op          (head_op),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_span_length (o_span_length),
        .o_pixel_value (o_pixel_value),
        .o_frame_last  (o_frame_last)
    );

endmodule
